>>> rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants, types and the memory request bundle of the merge sorter.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  // One write port and two read ports of a bank.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

endpackage

>>> rtl/msc_bank.sv
// ----------------------------------------------------------------------------
// msc_bank
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module msc_bank #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/msc_ctrl.sv
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer: loads the batch into bank 0, runs bottom-up merge passes that
// ping-pong between the two banks, then streams the sorted words out.
// ----------------------------------------------------------------------------
module msc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  msc_pkg::data_t    value,
  input  logic              final_req,
  output msc_pkg::mem_req_t req0,
  output msc_pkg::mem_req_t req1,
  input  msc_pkg::data_t    rd0_a,
  input  msc_pkg::data_t    rd0_b,
  input  msc_pkg::data_t    rd1_a,
  input  msc_pkg::data_t    rd1_b,
  output msc_pkg::data_t    sorted_value,
  output logic              strobe,
  output logic              last_out,
  output logic              overflow
);
  import msc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK,
    ST_RD,
    ST_CMP,
    ST_EMIT
  } state_t;

  state_t state;
  cnt_t   fill;
  logic   dropped;
  cnt_t   k, i, j, mid, hi, w;
  logic   src;

  data_t            head_l, head_r, merged;
  logic             take_left;
  logic             has_room;
  cnt_t             fill_next;
  logic [CNT_W:0]   lo_w, lo_2w, w2, k_inc;
  cnt_t             mid_c, hi_c;

  assign head_l    = src ? rd1_a : rd0_a;
  assign head_r    = src ? rd1_b : rd0_b;
  assign take_left = (i < mid) && ((j >= hi) || (head_l <= head_r));
  assign merged    = take_left ? head_l : head_r;

  assign has_room  = (fill < cnt_t'(CAPACITY));
  assign fill_next = has_room ? fill + cnt_t'(1) : fill;

  // Run boundaries of the block that starts at k, clipped to the batch size.
  assign lo_w  = {1'b0, k} + {1'b0, w};
  assign lo_2w = {1'b0, k} + {w, 1'b0};
  assign w2    = {w, 1'b0};
  assign k_inc = {1'b0, k} + (CNT_W+1)'(1);
  assign mid_c = (lo_w  > {1'b0, fill}) ? fill : lo_w[CNT_W-1:0];
  assign hi_c  = (lo_2w > {1'b0, fill}) ? fill : lo_2w[CNT_W-1:0];

  assign busy         = (state != ST_IDLE);
  assign sorted_value = head_l;

  always_comb begin
    req0.we      = ((state == ST_IDLE) && start && has_room) || ((state == ST_CMP) && src);
    req0.waddr   = (state == ST_IDLE) ? fill[ADDR_W-1:0] : k[ADDR_W-1:0];
    req0.wdata   = (state == ST_IDLE) ? value : merged;
    req0.raddr_a = (state == ST_EMIT) ? k[ADDR_W-1:0] : i[ADDR_W-1:0];
    req0.raddr_b = j[ADDR_W-1:0];
    req1.we      = (state == ST_CMP) && !src;
    req1.waddr   = k[ADDR_W-1:0];
    req1.wdata   = merged;
    req1.raddr_a = req0.raddr_a;
    req1.raddr_b = req0.raddr_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      dropped  <= 1'b0;
      k        <= '0;
      i        <= '0;
      j        <= '0;
      mid      <= '0;
      hi       <= '0;
      w        <= '0;
      src      <= 1'b0;
      strobe   <= 1'b0;
      last_out <= 1'b0;
      overflow <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            fill <= fill_next;
            if (!has_room) begin
              dropped <= 1'b1;
            end
            if (final_req) begin
              k     <= '0;
              w     <= cnt_t'(1);
              src   <= 1'b0;
              state <= (fill_next > cnt_t'(1)) ? ST_BLK : ST_EMIT;
            end
          end
        end
        ST_BLK: begin
          i     <= k;
          mid   <= mid_c;
          j     <= mid_c;
          hi    <= hi_c;
          state <= ST_RD;
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (take_left) begin
            i <= i + cnt_t'(1);
          end else begin
            j <= j + cnt_t'(1);
          end
          k <= k_inc[CNT_W-1:0];
          if (k_inc == {1'b0, hi}) begin
            if (hi == fill) begin
              // Pass complete: double the run width and swap banks.
              k     <= '0;
              w     <= w2[CNT_W-1:0];
              src   <= ~src;
              state <= (w2 >= {1'b0, fill}) ? ST_EMIT : ST_BLK;
            end else begin
              state <= ST_BLK;
            end
          end else begin
            state <= ST_RD;
          end
        end
        ST_EMIT: begin
          // The word read here appears on the result ports in the next cycle, with strobe.
          strobe   <= 1'b1;
          last_out <= (k_inc == {1'b0, fill});
          overflow <= dropped;
          k        <= k_inc[CNT_W-1:0];
          if (k_inc == {1'b0, fill}) begin
            fill    <= '0;
            dropped <= 1'b0;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_write_in_batch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (k < fill))
    else $error("merge write beyond batch");

  a_run_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> ((i < mid) || (j < hi)))
    else $error("merge step with both runs exhausted");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_out) |=> !strobe)
    else $error("result after last word");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= cnt_t'(CAPACITY))
    else $error("fill count beyond capacity");

endmodule

>>> rtl/merge_sorter_core.sv
// ----------------------------------------------------------------------------
// merge_sorter_core
// Stable ascending sorter for batches of signed words, built around two
// ping-pong RAM banks and a merge sequencer.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------
//  input    | start, busy      | value, final_req
//  result   | strobe           | sorted_value, last_out, overflow
//
//  Loading accepts one word per cycle while busy is low. After the final
//  word, each merge pass gives every element a bank read, then a single
//  compare-and-write step, and each merged block a boundary setup step;
//  ceil(log2 n) passes run. Emitting then streams the sorted words out.
//  Reset (rst, synchronous) empties the batch; RAM contents are not cleared.
//  Results cannot be stalled; busy stays high from the final word until the
//  last result has been read out of the bank.
// ----------------------------------------------------------------------------
module merge_sorter_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  msc_pkg::data_t value,
  input  logic           final_req,
  output msc_pkg::data_t sorted_value,
  output logic           strobe,
  output logic           last_out,
  output logic           overflow
);
  import msc_pkg::*;

  mem_req_t req0, req1;
  data_t    rd0_a, rd0_b, rd1_a, rd1_b;

  msc_bank #(.DEPTH(CAPACITY), .WIDTH(DATA_WIDTH)) u_bank0 (
    .clk     (clk),
    .we      (req0.we),
    .waddr   (req0.waddr),
    .wdata   (req0.wdata),
    .raddr_a (req0.raddr_a),
    .raddr_b (req0.raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  msc_bank #(.DEPTH(CAPACITY), .WIDTH(DATA_WIDTH)) u_bank1 (
    .clk     (clk),
    .we      (req1.we),
    .waddr   (req1.waddr),
    .wdata   (req1.wdata),
    .raddr_a (req1.raddr_a),
    .raddr_b (req1.raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  msc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .final_req    (final_req),
    .req0         (req0),
    .req1         (req1),
    .rd0_a        (rd0_a),
    .rd0_b        (rd0_b),
    .rd1_a        (rd1_a),
    .rd1_b        (rd1_b),
    .sorted_value (sorted_value),
    .strobe       (strobe),
    .last_out     (last_out),
    .overflow     (overflow)
  );

endmodule
